// ----- design/hcbd_pkg.sv -----
// Shared types, constants and helpers for the chunked body decoder.
// Used by every module of the block; depends on nothing else.
package hcbd_pkg;

    // Default width of the chunk size counter.
    localparam int SIZE_BITS_DEF = 32;

    // Characters that steer the size line and trailer parsing.
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_F = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;

    // Final verdict codes.
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_BAD        = 2'd2;

    // One classified body byte as it travels from front to back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
        logic       is_ws;
        logic       is_hex;
        logic [3:0] hex_val;
    } byte_class_t;

    // Parser phases, one-hot.
    typedef enum logic [10:0] {
        PH_LINE    = 11'b000_0000_0001,
        PH_LINE_CR = 11'b000_0000_0010,
        PH_EXT     = 11'b000_0000_0100,
        PH_EXT_CR  = 11'b000_0000_1000,
        PH_DATA    = 11'b000_0001_0000,
        PH_DCR     = 11'b000_0010_0000,
        PH_DLF     = 11'b000_0100_0000,
        PH_TSTART  = 11'b000_1000_0000,
        PH_TSCR    = 11'b001_0000_0000,
        PH_TMID    = 11'b010_0000_0000,
        PH_TMCR    = 11'b100_0000_0000
    } phase_t;

    // Sorts one raw byte into the classes the parser looks at.
    function automatic byte_class_t classify(input logic [7:0] b, input logic last);
        byte_class_t c;
        c.data    = b;
        c.last    = last;
        c.is_cr   = (b == CH_CR);
        c.is_lf   = (b == CH_LF);
        c.is_semi = (b == CH_SEMI);
        c.is_ws   = (b == CH_SP) || (b == CH_TAB);
        c.is_hex  = 1'b0;
        c.hex_val = 4'd0;
        if (b inside {[CH_D0:CH_D9]})
        begin
            c.is_hex  = 1'b1;
            c.hex_val = 4'(b - CH_D0);
        end
        else if (b inside {[CH_LA:CH_LF_F]})
        begin
            c.is_hex  = 1'b1;
            c.hex_val = 4'(b - CH_LA + 8'd10);
        end
        else if (b inside {[CH_UA:CH_UF]})
        begin
            c.is_hex  = 1'b1;
            c.hex_val = 4'(b - CH_UA + 8'd10);
        end
        return c;
    endfunction

endpackage

// ----- design/http_chunked_body_decoder.sv -----
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
//
// Usage: raw body bytes enter on in_byte with in_last marking the final
// buffered byte, under the in_valid / in_ready handshake. Every accepted
// item produces exactly one result item on the res_valid / res_ready
// handshake: out_valid with out_byte carries a decoded data byte, and
// final_res with status carries the body's verdict (complete, incomplete
// input or malformed encoding). Once a verdict has gone out, every later
// item yields an all-zero result until reset.
// A result passes from the front register through the queue to the result
// register before it is shown. Throughput is one item per clock while the
// receiver holds res_ready high; the back stage parser steps once per item.
// The front stage and a two-entry queue let input keep flowing while a
// result waits; when the receiver stalls, the result register holds and the
// queue fills, and in_ready falls only once both front and queue are full.
// Reset is asynchronous and active low; it empties the pipeline and puts
// the parser at the start of a size line with no verdict given.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       final_res,
    output logic [1:0] status
);
    import hcbd_pkg::*;

    // Classified byte handed from front to queue.
    logic        push;
    byte_class_t push_item;
    logic        q_full;

    // Queue head seen by the parser.
    logic        q_not_empty;
    byte_class_t head;
    logic        pop;

    hcbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    // The parser steps once per pop; one item per clock while res_ready holds.
    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .final_res   (final_res),
        .status      (status)
    );

endmodule

// ----- design/hcbd_front.sv -----
// Front stage: accepts raw body bytes and registers them classified.
// Depends on hcbd_pkg.
module hcbd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 push,
    output hcbd_pkg::byte_class_t push_item,
    input  logic                 q_full
);
    import hcbd_pkg::*;

    logic        f_valid_reg;
    logic        f_valid_next;
    byte_class_t f_item_reg;
    logic        accept;

    assign push      = f_valid_reg && !q_full;
    assign push_item = f_item_reg;
    assign in_ready  = !f_valid_reg || !q_full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
            f_valid_next = 1'b1;
        else if (push)
            f_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            f_item_reg <= classify(in_byte, in_last);
    end

endmodule

// ----- design/hcbd_queue.sv -----
// Two-entry queue of classified bytes between front and back.
// Depends on hcbd_pkg.
module hcbd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hcbd_pkg::byte_class_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output hcbd_pkg::byte_class_t head
);
    import hcbd_pkg::*;

    byte_class_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- design/hcbd_back.sv -----
// Back stage: chunked coding parser and result register.
// Depends on hcbd_pkg; takes classified bytes from hcbd_queue.
module hcbd_back #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  hcbd_pkg::byte_class_t head,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  final_res,
    output logic [1:0]            status
);
    import hcbd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] chunk_reg, chunk_next;
    logic                 seen_digit_reg, seen_digit_next;
    logic                 nonempty_reg, nonempty_next;
    logic                 bad_reg, bad_next;
    logic                 given_reg, given_next;

    logic                 rv_reg;
    logic                 ov_reg, ov_next;
    logic [7:0]           ob_reg, ob_next;
    logic                 fin_reg, fin_next;
    logic [1:0]           st_reg, st_next;

    logic                 do_size;
    logic                 verdict_hit;
    logic [1:0]           verdict;
    logic                 line_ok;
    logic                 size_ovf;

    assign pop       = q_not_empty && (!rv_reg || res_ready);
    assign res_valid = rv_reg;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign final_res = fin_reg;
    assign status    = st_reg;

    // Another digit would push the size past SIZE_BITS when the top nibble is set.
    assign size_ovf = (chunk_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign line_ok  = nonempty_reg && !bad_reg && seen_digit_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        chunk_next      = chunk_reg;
        seen_digit_next = seen_digit_reg;
        nonempty_next   = nonempty_reg;
        bad_next        = bad_reg;
        given_next      = given_reg;
        do_size         = 1'b0;
        verdict_hit     = 1'b0;
        verdict         = ST_DONE;
        ov_next         = 1'b0;
        ob_next         = 8'd0;

        if (!given_reg)
        begin
            case (phase_reg)
                PH_LINE:
                begin
                    if (head.is_cr)
                        phase_next = PH_LINE_CR;
                    else
                        do_size = 1'b1;
                end
                PH_LINE_CR:
                begin
                    if (head.is_lf)
                    begin
                        if (!line_ok)
                        begin
                            verdict_hit = 1'b1;
                            verdict     = ST_BAD;
                        end
                        else if (chunk_reg == '0)
                            phase_next = PH_TSTART;
                        else
                            phase_next = PH_DATA;
                    end
                    else
                    begin
                        // The held CR was a stray byte inside the line.
                        nonempty_next = 1'b1;
                        bad_next      = 1'b1;
                        do_size       = !head.is_cr;
                    end
                end
                PH_EXT:
                begin
                    nonempty_next = 1'b1;
                    if (head.is_cr)
                        phase_next = PH_EXT_CR;
                end
                PH_EXT_CR:
                begin
                    if (head.is_lf)
                    begin
                        if (!line_ok)
                        begin
                            verdict_hit = 1'b1;
                            verdict     = ST_BAD;
                        end
                        else if (chunk_reg == '0)
                            phase_next = PH_TSTART;
                        else
                            phase_next = PH_DATA;
                    end
                    else if (!head.is_cr)
                        phase_next = PH_EXT;
                end
                PH_DATA:
                begin
                    ov_next    = 1'b1;
                    ob_next    = head.data;
                    chunk_next = chunk_reg - SIZE_BITS'(1);
                    if (chunk_reg == SIZE_BITS'(1))
                        phase_next = PH_DCR;
                end
                PH_DCR:
                begin
                    bad_next   = !head.is_cr;
                    phase_next = PH_DLF;
                end
                PH_DLF:
                begin
                    if (bad_reg || !head.is_lf)
                    begin
                        verdict_hit = 1'b1;
                        verdict     = ST_BAD;
                    end
                    else
                    begin
                        phase_next      = PH_LINE;
                        chunk_next      = '0;
                        seen_digit_next = 1'b0;
                        nonempty_next   = 1'b0;
                        bad_next        = 1'b0;
                    end
                end
                PH_TSTART:
                    phase_next = head.is_cr ? PH_TSCR : PH_TMID;
                PH_TSCR:
                begin
                    if (head.is_lf)
                    begin
                        verdict_hit = 1'b1;
                        verdict     = ST_DONE;
                    end
                    else
                        phase_next = head.is_cr ? PH_TMCR : PH_TMID;
                end
                PH_TMID:
                begin
                    if (head.is_cr)
                        phase_next = PH_TMCR;
                end
                PH_TMCR:
                begin
                    if (head.is_lf)
                        phase_next = PH_TSTART;
                    else if (!head.is_cr)
                        phase_next = PH_TMID;
                end
                default:
                begin
                    phase_next      = PH_LINE;
                    chunk_next      = '0;
                    seen_digit_next = 1'b0;
                    nonempty_next   = 1'b0;
                    bad_next        = 1'b0;
                end
            endcase

            // One byte of a size line ahead of the semicolon.
            if (do_size)
            begin
                nonempty_next = 1'b1;
                if (head.is_semi)
                    phase_next = PH_EXT;
                else
                begin
                    phase_next = PH_LINE;
                    if (!head.is_ws)
                    begin
                        if (!head.is_hex)
                            bad_next = 1'b1;
                        else
                        begin
                            seen_digit_next = 1'b1;
                            if (size_ovf)
                                bad_next = 1'b1;
                            else if (!bad_next)
                                chunk_next = {chunk_reg[SIZE_BITS-5:0], head.hex_val};
                        end
                    end
                end
            end

            if (!verdict_hit && head.last)
            begin
                verdict_hit = 1'b1;
                verdict     = ST_INCOMPLETE;
            end
            if (verdict_hit)
                given_next = 1'b1;
        end

        fin_next = verdict_hit;
        st_next  = verdict_hit ? verdict : ST_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LINE;
            chunk_reg      <= '0;
            seen_digit_reg <= 1'b0;
            nonempty_reg   <= 1'b0;
            bad_reg        <= 1'b0;
            given_reg      <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                chunk_reg      <= chunk_next;
                seen_digit_reg <= seen_digit_next;
                nonempty_reg   <= nonempty_next;
                bad_reg        <= bad_next;
                given_reg      <= given_next;
                rv_reg         <= 1'b1;
            end
            else if (res_ready)
                rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ov_reg  <= ov_next;
            ob_reg  <= ob_next;
            fin_reg <= fin_next;
            st_reg  <= st_next;
        end
    end

endmodule

// ----- design/hcbd_checker.sv -----
// Port-level checker for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg for the verdict codes.
module hcbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       out_valid,
    input logic [7:0] out_byte,
    input logic       final_res,
    input logic [1:0] status
);
    import hcbd_pkg::*;

    // Set once a verdict has been delivered.
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else if (res_valid && res_ready && final_res)
            done_reg <= 1'b1;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_valid) && $stable(out_byte)
            && $stable(final_res) && $stable(status))
        else $error("result changed while stalled");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (out_valid || out_byte == 8'd0) && (final_res || status == ST_DONE))
        else $error("unused result field not zero");

    a_data_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid && final_res |-> status == ST_INCOMPLETE)
        else $error("data byte with a verdict other than incomplete");

    a_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_reg |-> !out_valid && !final_res)
        else $error("result produced after the verdict");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .final_res (final_res),
    .status    (status)
);
